[rtl/assert_macros.svh]
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/sbb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the sprite batch builder.
package sbb_pkg;

    localparam int TEXTURE_SLOTS   = 32;
    localparam int MAX_BATCH_QUADS = 16384;
    localparam int SLOT_W          = $clog2(TEXTURE_SLOTS);
    localparam int NEXT_W          = SLOT_W + 1;
    localparam int QUAD_W          = 15;
    localparam int TEX_W           = 16;
    localparam int WORD_W          = 32;
    localparam int CMD_W           = 2;
    localparam int Q_DEPTH         = 2;

    localparam logic [QUAD_W-1:0] QUAD_LIMIT_RST = QUAD_W'(10000);

    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_BEGIN,
        OP_END
    } t_op;

    // One classified command with its quad corners already worked out.
    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] x_lo;
        logic [WORD_W-1:0] x_hi;
        logic [WORD_W-1:0] y_lo;
        logic [WORD_W-1:0] y_hi;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] color;
        logic [TEX_W-1:0]  tex;
        logic [WORD_W-1:0] entity;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_push;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic              u;
        logic              v;
        logic [WORD_W-1:0] color;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] entity;
        logic [QUAD_W-1:0] quads;
        logic              last;
    } t_res;

endpackage

[rtl/sbb_front.sv]
`timescale 1ns / 1ps
// Front end: accepts commands, classifies them and works out the quad corners.
module sbb_front (
    input  logic                              i_in_valid,
    input  logic [sbb_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_x,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_y,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_z,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_size_w,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_size_h,
    input  logic [sbb_pkg::WORD_W-1:0]        i_color_rgba,
    input  logic [sbb_pkg::TEX_W-1:0]         i_texture_id,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_entity_id,
    output logic                              o_in_stall,
    input  logic                              i_q_full,
    output sbb_pkg::t_q_push                  o_push
);
    import sbb_pkg::*;

    logic [WORD_W-1:0] half_w;
    logic [WORD_W-1:0] half_h;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic              keep;
    t_op               op;

    assign pos_x  = i_pos_x;
    assign pos_y  = i_pos_y;
    // arithmetic shift: keep the sign bit
    assign half_w = {i_size_w[WORD_W-1], i_size_w[WORD_W-1:1]};
    assign half_h = {i_size_h[WORD_W-1], i_size_h[WORD_W-1:1]};

    always_comb begin
        op   = OP_DRAW;
        keep = 1'b1;
        unique case (i_cmd)
            CMD_DRAW:  op = OP_DRAW;
            CMD_BEGIN: op = OP_BEGIN;
            CMD_END:   op = OP_END;
            default:   keep = 1'b0;   // unused code: accept and drop
        endcase
    end

    always_comb begin
        o_push.item.op     = op;
        o_push.item.x_lo   = pos_x - half_w;
        o_push.item.x_hi   = pos_x + half_w;
        o_push.item.y_lo   = pos_y - half_h;
        o_push.item.y_hi   = pos_y + half_h;
        o_push.item.z      = i_pos_z;
        o_push.item.color  = i_color_rgba;
        o_push.item.tex    = i_texture_id;
        o_push.item.entity = i_entity_id;
        o_push.push        = i_in_valid && !i_q_full && keep;
    end

    assign o_in_stall = i_q_full;

endmodule

[rtl/sbb_queue.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the batch sequencer.
module sbb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbb_pkg::t_q_push i_push,
    output logic             o_full,
    output sbb_pkg::t_q_head o_head,
    input  logic             i_pop
);
    import sbb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

    t_item            r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    assign o_full       = (r_count == CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

[rtl/sbb_back.sv]
`timescale 1ns / 1ps
// Batch sequencer: slot binding, flush decisions, vertex output register.
module sbb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [sbb_pkg::QUAD_W-1:0] i_cfg_data,
    input  sbb_pkg::t_q_head          i_head,
    output logic                      o_pop,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output sbb_pkg::t_res             o_res
);
    import sbb_pkg::*;

    localparam logic [QUAD_W-1:0] MAX_Q = QUAD_W'(MAX_BATCH_QUADS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_VERT
    } t_state;

    t_state            r_state,       n_state;
    logic [QUAD_W-1:0] r_quad_limit;
    logic [QUAD_W-1:0] r_quad_count,  n_quad_count;
    logic [NEXT_W-1:0] r_next_slot,   n_next_slot;
    t_item             r_item,        n_item;
    logic              r_hit,         n_hit;
    logic [SLOT_W-1:0] r_hit_idx,     n_hit_idx;
    logic [SLOT_W-1:0] r_slot,        n_slot;
    logic [1:0]        r_corner,      n_corner;
    logic              r_out_valid,   n_out_valid;
    t_res              r_out,         n_out;
    logic [TEX_W-1:0]  r_slot_tex [TEXTURE_SLOTS];

    logic                     can_load;
    logic [QUAD_W-1:0]        lim;
    logic                     force_flush;
    logic                     has_quads;
    logic                     slots_full;
    logic [TEXTURE_SLOTS-1:0] match_vec;
    logic [SLOT_W-1:0]        hit_idx;
    logic                     slot_we;
    logic [SLOT_W-1:0]        slot_waddr;

    function automatic t_res mk_marker(logic [QUAD_W-1:0] quads, logic last);
        t_res r;
        r       = '0;
        r.kind  = 1'b1;
        r.quads = quads;
        r.last  = last;
        return r;
    endfunction

    function automatic t_res mk_vertex(t_item it, logic [SLOT_W-1:0] slot, logic [1:0] k);
        t_res r;
        logic u;
        logic v;
        u        = k[0] ^ k[1];
        v        = k[1];
        r        = '0;
        r.x      = u ? it.x_hi : it.x_lo;
        r.y      = v ? it.y_hi : it.y_lo;
        r.z      = it.z;
        r.u      = u;
        r.v      = v;
        r.color  = it.color;
        r.slot   = slot;
        r.entity = it.entity;
        r.last   = (k == 2'd3);
        return r;
    endfunction

    assign can_load    = !r_out_valid || !i_out_stall;
    assign lim         = (r_quad_limit > MAX_Q) ? MAX_Q : r_quad_limit;
    assign force_flush = (r_quad_count >= lim);
    assign has_quads   = (r_quad_count != '0);
    assign slots_full  = (r_next_slot >= NEXT_W'(TEXTURE_SLOTS));

    // compare the texture against every bound slot of the batch at once
    always_comb begin
        for (int i = 0; i < TEXTURE_SLOTS; i++) begin
            match_vec[i] = (i != 0) && (NEXT_W'(i) < r_next_slot)
                           && (r_slot_tex[i] == r_item.tex);
        end
        hit_idx = '0;
        for (int i = TEXTURE_SLOTS - 1; i >= 1; i--) begin
            if (match_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_quad_count = r_quad_count;
        n_next_slot  = r_next_slot;
        n_item       = r_item;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_slot       = r_slot;
        n_corner     = r_corner;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_pop        = 1'b0;
        slot_we      = 1'b0;
        slot_waddr   = r_next_slot[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.item.op)
                        OP_BEGIN: begin
                            o_pop        = 1'b1;
                            n_quad_count = '0;
                            n_next_slot  = NEXT_W'(1);
                        end
                        OP_END: begin
                            if (!has_quads) begin
                                o_pop = 1'b1;
                            end else if (can_load) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = mk_marker(r_quad_count, 1'b1);
                            end
                        end
                        OP_DRAW: begin
                            o_pop   = 1'b1;
                            n_item  = i_head.item;
                            n_state = S_CHECK;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_CHECK: begin
                // hold while a forced marker has no room
                if (!(force_flush && has_quads && !can_load)) begin
                    if (force_flush) begin
                        if (has_quads) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_marker(r_quad_count, 1'b0);
                        end
                        n_quad_count = '0;
                        n_next_slot  = NEXT_W'(1);
                    end
                    n_hit     = !force_flush && (match_vec != '0);
                    n_hit_idx = hit_idx;
                    n_state   = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (!(r_item.tex != '0 && !r_hit && slots_full && has_quads && !can_load)) begin
                    n_quad_count = r_quad_count + 1'b1;
                    n_corner     = '0;
                    n_state      = S_VERT;
                    if (r_item.tex == '0) begin
                        n_slot = '0;
                    end else if (r_hit) begin
                        n_slot = r_hit_idx;
                    end else if (slots_full) begin
                        // out of slots: flush and bind to the first free one
                        if (has_quads) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_marker(r_quad_count, 1'b0);
                        end
                        n_quad_count = QUAD_W'(1);
                        slot_we      = 1'b1;
                        slot_waddr   = SLOT_W'(1);
                        n_slot       = SLOT_W'(1);
                        n_next_slot  = NEXT_W'(2);
                    end else begin
                        slot_we     = 1'b1;
                        n_slot      = r_next_slot[SLOT_W-1:0];
                        n_next_slot = r_next_slot + 1'b1;
                    end
                end
            end
            S_VERT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_vertex(r_item, r_slot, r_corner);
                    n_corner    = r_corner + 1'b1;
                    if (r_corner == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_quad_limit <= QUAD_LIMIT_RST;
            r_quad_count <= '0;
            r_next_slot  <= NEXT_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_quad_count <= n_quad_count;
            r_next_slot  <= n_next_slot;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_quad_limit <= i_cfg_data;
            end
        end
        r_item    <= n_item;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_slot    <= n_slot;
        r_corner  <= n_corner;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_tex[slot_waddr] <= r_item.tex;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[rtl/sprite_batch_builder.sv]
`timescale 1ns / 1ps
// Top level of the sprite batch builder.
//
//  channel  direction  handshake              payload
//  in       sink       i_in_valid/o_in_stall  i_cmd, position, size, color, texture, entity
//  out      source     o_out_valid/i_out_stall vertex or flush marker fields
//  cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_data (quad limit)
//
// A draw passes through the sequencer in order: dispatch, slot tag compare, slot bind,
// then one vertex a cycle from the output register while the output is not stalled;
// a flush marker shares the compare or bind cycle. Begin and end scene are handled at dispatch.
// A two-entry queue lets the front end accept while the sequencer works.
// Reset is synchronous; the slot table has no reset and needs no clearing pass.
// A stalled output holds its item; the sequencer waits on it.
`include "assert_macros.svh"
module sprite_batch_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sbb_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_x,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_y,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_pos_z,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_size_w,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_size_h,
    input  logic [sbb_pkg::WORD_W-1:0]        i_color_rgba,
    input  logic [sbb_pkg::TEX_W-1:0]         i_texture_id,
    input  logic signed [sbb_pkg::WORD_W-1:0] i_entity_id,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_kind,
    output logic signed [sbb_pkg::WORD_W-1:0] o_vert_x,
    output logic signed [sbb_pkg::WORD_W-1:0] o_vert_y,
    output logic signed [sbb_pkg::WORD_W-1:0] o_vert_z,
    output logic                              o_tex_u,
    output logic                              o_tex_v,
    output logic [sbb_pkg::WORD_W-1:0]        o_vert_color,
    output logic [sbb_pkg::SLOT_W-1:0]        o_tex_slot,
    output logic signed [sbb_pkg::WORD_W-1:0] o_vert_entity,
    output logic [sbb_pkg::QUAD_W-1:0]        o_batch_quads,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbb_pkg::QUAD_W-1:0]        i_cfg_data
);
    import sbb_pkg::*;

    t_q_push q_push;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;
    t_res    res;

    sbb_front u_front (
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_size_w     (i_size_w),
        .i_size_h     (i_size_h),
        .i_color_rgba (i_color_rgba),
        .i_texture_id (i_texture_id),
        .i_entity_id  (i_entity_id),
        .o_in_stall   (o_in_stall),
        .i_q_full     (q_full),
        .o_push       (q_push)
    );

    sbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    sbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_kind        = res.kind;
    assign o_vert_x      = $signed(res.x);
    assign o_vert_y      = $signed(res.y);
    assign o_vert_z      = $signed(res.z);
    assign o_tex_u       = res.u;
    assign o_tex_v       = res.v;
    assign o_vert_color  = res.color;
    assign o_tex_slot    = res.slot;
    assign o_vert_entity = $signed(res.entity);
    assign o_batch_quads = res.quads;
    assign o_last        = res.last;

    // a marker is only sent for a non-empty batch
    `ASSERT_RST(a_marker_nonempty, i_clk, i_rst_n, o_out_valid && o_kind |-> o_batch_quads != '0)
    // the closing vertex of a quad is the low-x, high-y corner
    `ASSERT_RST(a_last_corner, i_clk, i_rst_n, o_out_valid && !o_kind && o_last |-> !o_tex_u && o_tex_v)
    // reset empties the output register
    `ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

[tb/sprite_batch_checker.sv]
`timescale 1ns / 1ps
// Checker for the sprite batch builder: batching predictor and result compare.
module sprite_batch_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic [sbb_pkg::CMD_W-1:0]     i_cmd,
    input  logic [sbb_pkg::WORD_W-1:0]    i_pos_x,
    input  logic [sbb_pkg::WORD_W-1:0]    i_pos_y,
    input  logic [sbb_pkg::WORD_W-1:0]    i_pos_z,
    input  logic [sbb_pkg::WORD_W-1:0]    i_size_w,
    input  logic [sbb_pkg::WORD_W-1:0]    i_size_h,
    input  logic [sbb_pkg::WORD_W-1:0]    i_color_rgba,
    input  logic [sbb_pkg::TEX_W-1:0]     i_texture_id,
    input  logic [sbb_pkg::WORD_W-1:0]    i_entity_id,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_kind,
    input  logic [sbb_pkg::WORD_W-1:0]    o_vert_x,
    input  logic [sbb_pkg::WORD_W-1:0]    o_vert_y,
    input  logic [sbb_pkg::WORD_W-1:0]    o_vert_z,
    input  logic                          o_tex_u,
    input  logic                          o_tex_v,
    input  logic [sbb_pkg::WORD_W-1:0]    o_vert_color,
    input  logic [sbb_pkg::SLOT_W-1:0]    o_tex_slot,
    input  logic [sbb_pkg::WORD_W-1:0]    o_vert_entity,
    input  logic [sbb_pkg::QUAD_W-1:0]    o_batch_quads,
    input  logic                          o_last,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [sbb_pkg::QUAD_W-1:0]    i_cfg_data,
    output int                            mismatches,
    output int                            results_pending,
    output int                            results_seen,
    output int                            markers_seen
);
    import sbb_pkg::*;

    logic [QUAD_W-1:0] limit_reg;
    int unsigned       batch_quads;
    int unsigned       free_slot;
    logic [TEX_W-1:0]  bound_tex [TEXTURE_SLOTS];
    t_res              batch_backlog [$];
    int                fail_cnt;
    int                seen_cnt;
    int                marker_cnt;

    function automatic string describe(input t_res r);
        return $sformatf({"kind=%0d x=%h y=%h z=%h u=%0d v=%0d color=%h slot=%0d ",
                          "entity=%h quads=%0d last=%0d"},
                         r.kind, r.x, r.y, r.z, r.u, r.v, r.color, r.slot,
                         r.entity, r.quads, r.last);
    endfunction

    // Queue a flush marker if the batch holds any quads.
    task automatic close_batch(input logic is_last);
        t_res r;
        r = '0;
        if (batch_quads != 0) begin
            r.kind  = 1'b1;
            r.quads = batch_quads[QUAD_W-1:0];
            r.last  = is_last;
            batch_backlog.push_back(r);
        end
    endtask

    task automatic run_batcher();
        int unsigned              lim;
        int unsigned              slot;
        logic signed [WORD_W-1:0] half_w;
        logic signed [WORD_W-1:0] half_h;
        logic [WORD_W-1:0]        x_lo, x_hi, y_lo, y_hi;
        t_res                     r;
        if (i_cmd == CMD_BEGIN) begin
            batch_quads = 0;
            free_slot   = 1;
        end else if (i_cmd == CMD_END) begin
            close_batch(1'b1);
        end else if (i_cmd == CMD_DRAW) begin
            lim = (limit_reg > MAX_BATCH_QUADS) ? MAX_BATCH_QUADS : limit_reg;
            if (batch_quads >= lim) begin
                close_batch(1'b0);
                batch_quads = 0;
                free_slot   = 1;
            end
            slot = 0;
            if (i_texture_id != '0) begin
                for (int i = 1; i < free_slot && i < TEXTURE_SLOTS; i++)
                    if (slot == 0 && bound_tex[i] == i_texture_id)
                        slot = i;
                if (slot == 0) begin
                    if (free_slot >= TEXTURE_SLOTS) begin
                        close_batch(1'b0);
                        batch_quads = 0;
                        free_slot   = 1;
                    end
                    slot = free_slot;
                    bound_tex[slot] = i_texture_id;
                    free_slot++;
                end
            end
            half_w = $signed(i_size_w) >>> 1;
            half_h = $signed(i_size_h) >>> 1;
            x_lo = i_pos_x - half_w;
            x_hi = i_pos_x + half_w;
            y_lo = i_pos_y - half_h;
            y_hi = i_pos_y + half_h;
            // Corners go lo/lo, hi/lo, hi/hi, lo/hi.
            for (int k = 0; k < 4; k++) begin
                r        = '0;
                r.u      = (k == 1 || k == 2);
                r.v      = (k >= 2);
                r.x      = r.u ? x_hi : x_lo;
                r.y      = r.v ? y_hi : y_lo;
                r.z      = i_pos_z;
                r.color  = i_color_rgba;
                r.slot   = slot[SLOT_W-1:0];
                r.entity = i_entity_id;
                r.last   = (k == 3);
                batch_backlog.push_back(r);
            end
            batch_quads++;
        end
        // any other command is dropped
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res exp;
        if (!i_rst_n) begin
            limit_reg   = QUAD_LIMIT_RST;
            batch_quads = 0;
            free_slot   = 1;
            for (int i = 0; i < TEXTURE_SLOTS; i++)
                bound_tex[i] = '0;
            batch_backlog.delete();
            fail_cnt   = 0;
            seen_cnt   = 0;
            marker_cnt = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                limit_reg = i_cfg_data;
            if (i_in_valid && !o_in_stall)
                run_batcher();
            if (o_out_valid && !i_out_stall) begin
                got = '{kind: o_kind, x: o_vert_x, y: o_vert_y, z: o_vert_z,
                        u: o_tex_u, v: o_tex_v, color: o_vert_color, slot: o_tex_slot,
                        entity: o_vert_entity, quads: o_batch_quads, last: o_last};
                seen_cnt++;
                if (o_kind === 1'b1)
                    marker_cnt++;
                if (batch_backlog.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("[%0t] unexpected result: %s", $time, describe(got));
                end else begin
                    exp = batch_backlog.pop_front();
                    if (got !== exp) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("[%0t] result mismatch", $time);
                            $display("    expected %s", describe(exp));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
        end
        mismatches      <= fail_cnt;
        results_pending <= batch_backlog.size();
        results_seen    <= seen_cnt;
        markers_seen    <= marker_cnt;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top: command and quad limit stimulus for the sprite batch builder.
module tb;
    import sbb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 36;
    localparam int SWEEP_ITEMS  = 34;
    localparam int SETTLE_CYC   = 30;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_cmd        = CMD_DRAW;
    logic [WORD_W-1:0]   i_pos_x      = '0;
    logic [WORD_W-1:0]   i_pos_y      = '0;
    logic [WORD_W-1:0]   i_pos_z      = '0;
    logic [WORD_W-1:0]   i_size_w     = '0;
    logic [WORD_W-1:0]   i_size_h     = '0;
    logic [WORD_W-1:0]   i_color_rgba = '0;
    logic [TEX_W-1:0]    i_texture_id = '0;
    logic [WORD_W-1:0]   i_entity_id  = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic                o_kind;
    logic [WORD_W-1:0]   o_vert_x;
    logic [WORD_W-1:0]   o_vert_y;
    logic [WORD_W-1:0]   o_vert_z;
    logic                o_tex_u;
    logic                o_tex_v;
    logic [WORD_W-1:0]   o_vert_color;
    logic [SLOT_W-1:0]   o_tex_slot;
    logic [WORD_W-1:0]   o_vert_entity;
    logic [QUAD_W-1:0]   o_batch_quads;
    logic                o_last;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [QUAD_W-1:0]   i_cfg_data   = '0;

    int    mismatches;
    int    results_pending;
    int    results_seen;
    int    markers_seen;

    t_idle idle_mode      = IDLE_NONE;
    int    commands_sent  = 0;
    int    draws_sent     = 0;
    int    limits_written = 0;

    sprite_batch_builder dut (.*);
    sprite_batch_checker checker_i (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_out_stall <= ($urandom_range(99) < 76);
            IDLE_BOTH:     i_out_stall <= ($urandom_range(99) < 20);
            default:       i_out_stall <= 1'b0;
        endcase
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [WORD_W-1:0] px, py, pz, sw, sh, color,
                                input logic [TEX_W-1:0] tex,
                                input logic [WORD_W-1:0] ent);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 20 : 0;
        while ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_pos_z      <= pz;
        i_size_w     <= sw;
        i_size_h     <= sh;
        i_color_rgba <= color;
        i_texture_id <= tex;
        i_entity_id  <= ent;
        do @(posedge i_clk); while (o_in_stall);
        commands_sent++;
        if (cmd == CMD_DRAW)
            draws_sent++;
    endtask

    // Hold the sender until every predicted result has come out, then let it settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [QUAD_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limits_written++;
    endtask

    function automatic logic [WORD_W-1:0] pick_size();
        if ($urandom_range(99) < 60)
            return $urandom();
        return {8'h00, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
    endfunction

    // A nonzero fresh_tex forces a draw that binds that texture.
    task automatic random_command(input int fresh_tex);
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [TEX_W-1:0] tex;
        r = $urandom_range(99);
        if (fresh_tex != 0 || r < 84)
            cmd = CMD_DRAW;
        else if (r < 92)
            cmd = CMD_END;
        else if (r < 96)
            cmd = CMD_BEGIN;
        else
            cmd = CMD_UNUSED;
        r = $urandom_range(99);
        if (fresh_tex != 0)
            tex = fresh_tex[TEX_W-1:0];
        else if (r < 15)
            tex = '0;
        else if (r < 45)
            tex = TEX_W'($urandom_range(1, 6));
        else
            tex = TEX_W'($urandom_range(0, 65535));
        send_command(cmd, $urandom(), $urandom(), $urandom(), pick_size(), pick_size(),
                     $urandom(), tex, $urandom());
    endtask

    initial begin
        logic [QUAD_W-1:0] phase_limit [PHASES];
        phase_limit = '{QUAD_W'(16384), QUAD_W'(2), QUAD_W'(32767), QUAD_W'(0),
                        QUAD_W'(10000), QUAD_W'(3), QUAD_W'(5), QUAD_W'(1)};
        phase_limit[6] = QUAD_W'($urandom_range(4, 40));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset quad limit.
        send_command(CMD_END, '0, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_DRAW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
        send_command(CMD_DRAW, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 32'h8000_0000);
        send_command(CMD_DRAW, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0004_0000,
                     32'h0003_0000, 32'h1122_3344, 16'hFFFF, 32'h0000_0000);
        send_command(CMD_DRAW, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_0003,
                     32'hFFFF_FFFD, 32'hA5A5_5A5A, 16'h0001, 32'h0000_0007);
        send_command(CMD_END, '0, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_DRAW, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0001_0000,
                     32'h0001_0000, 32'h00FF_00FF, 16'h0002, 32'h0000_0042);
        send_command(CMD_END, '0, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), 16'h00AB, $urandom());
        send_command(CMD_BEGIN, '0, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_END, '0, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_DRAW, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h8000_0001, 16'h8000, 32'h7FFF_FFFF);
        wait_drained();

        // Limit of one forces a flush on every draw after the first.
        write_limit(QUAD_W'(1));
        repeat (3) random_command(1 + $urandom_range(0, 3));
        send_command(CMD_END, '0, '0, '0, '0, '0, '0, '0, '0);
        write_limit(QUAD_W'(0));
        repeat (3) random_command(1 + $urandom_range(0, 3));

        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p]);
            idle_mode = t_idle'(p % 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Large limits: sweep distinct textures until the slots run out.
                if (phase_limit[p] >= 64 && i < SWEEP_ITEMS)
                    random_command(16'h1000 + p * 64 + i);
                else
                    random_command(0);
                if ($urandom_range(99) < 2)
                    wait_drained();
            end
        end
        wait_drained();

        $display("Summary: %0d commands (%0d draws) over %0d quad limit settings",
                 commands_sent, draws_sent, limits_written);
        $display("Summary: %0d results checked, %0d of them batch flush markers",
                 results_seen, markers_seen);
        if (mismatches == 0)
            $display("sprite_batch_builder verification clean");
        else
            $display("sprite_batch_builder verification failed");
        $finish;
    end

    initial begin
        #4_800_000;
        $display("sprite_batch_builder verification failed");
        $finish;
    end

endmodule
